### rtl/utf8_stream_decoder_core_defines.svh
// Assertion macros used by the checker file of the decoder.
`ifndef UTF8_STREAM_DECODER_CORE_DEFINES_SVH
`define UTF8_STREAM_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define UTF8_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define UTF8_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/utf8_dec_pkg.sv
package utf8_dec_pkg;

  localparam int unsigned CpWidth = 21;

  // Code point sent when a buffer ends inside a sequence ('?').
  localparam logic [CpWidth-1:0] ReplacementCp = 21'h00003F;

  // Input word: one byte of the buffer and its end marker.
  typedef struct packed {
    logic [7:0] byte_in;
    logic       buffer_end;
  } in_word_t;

  // Output word: one decoded code point.
  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic               replaced;
  } out_word_t;

  // Decoder state carried from one byte to the next.
  typedef struct packed {
    logic [1:0]         bytes_pending;
    logic [CpWidth-1:0] partial_value;
  } dec_state_t;

  // Kind of sequence that a lead byte opens.
  typedef enum logic [1:0] {
    LEAD_ONE,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR
  } lead_kind_t;

endpackage

### rtl/utf8_dec_step.sv
module utf8_dec_step
  import utf8_dec_pkg::*;
(
  input  dec_state_t state,
  input  in_word_t   word,
  output dec_state_t state_next,
  output logic       emit,
  output out_word_t  result
);

  lead_kind_t lead;

  // Classify the byte as a lead byte. Anything not recognized opens four bytes.
  always_comb begin
    unique case (word.byte_in) inside
      [8'h00:8'h7F]: lead = LEAD_ONE;
      [8'hC0:8'hDF]: lead = LEAD_TWO;
      [8'hE0:8'hEF]: lead = LEAD_THREE;
      default:       lead = LEAD_FOUR;
    endcase
  end

  // One byte step: emit ASCII, start a sequence, or shift in six payload bits.
  always_comb begin
    logic [CpWidth-1:0] shifted;
    logic [1:0]         remain;

    shifted    = {state.partial_value[CpWidth-7:0], word.byte_in[5:0]};
    remain     = state.bytes_pending - 2'd1;
    state_next = '0;
    emit       = 1'b0;
    result     = '{code_point: ReplacementCp, replaced: 1'b1};

    if (state.bytes_pending == 2'd0) begin
      if (lead == LEAD_ONE) begin
        emit   = 1'b1;
        result = '{code_point: {{(CpWidth-8){1'b0}}, word.byte_in}, replaced: 1'b0};
      end else if (word.buffer_end) begin
        emit = 1'b1;
      end else begin
        unique case (lead)
          LEAD_TWO: begin
            state_next.bytes_pending = 2'd1;
            state_next.partial_value = {{(CpWidth-5){1'b0}}, word.byte_in[4:0]};
          end
          LEAD_THREE: begin
            state_next.bytes_pending = 2'd2;
            state_next.partial_value = {{(CpWidth-4){1'b0}}, word.byte_in[3:0]};
          end
          default: begin
            state_next.bytes_pending = 2'd3;
            state_next.partial_value = {{(CpWidth-3){1'b0}}, word.byte_in[2:0]};
          end
        endcase
      end
    end else if (remain == 2'd0) begin
      // Last continuation byte completes the code point.
      emit   = 1'b1;
      result = '{code_point: shifted, replaced: 1'b0};
    end else if (word.buffer_end) begin
      // Buffer ended inside the sequence.
      emit = 1'b1;
    end else begin
      state_next.bytes_pending = remain;
      state_next.partial_value = shifted;
    end
  end

endmodule

### rtl/utf8_stream_decoder_core.sv
// A result word is registered on rsp, or in the skid entry while rsp stalls.
// Throughput: one byte per cycle while skid is empty; the decode step is
// a single pass of logic between the state register and the output register.
// Two-entry output (register, skid): bytes flow while rsp stalls until skid fills.
// Reset (synchronous, active high) clears the decoder state and empties the output.
module utf8_stream_decoder_core
  import utf8_dec_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  in_word_t  req_word,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output out_word_t rsp_word
);

  dec_state_t state;
  dec_state_t state_next;
  logic       emit;
  out_word_t  result;
  logic       skid_valid;
  out_word_t  skid_word;
  logic       req_fire;
  logic       rsp_fire;
  logic       new_word;

  utf8_dec_step u_step (
    .state      (state),
    .word       (req_word),
    .state_next (state_next),
    .emit       (emit),
    .result     (result)
  );

  assign req_ready = !skid_valid;
  assign req_fire  = req_valid && req_ready;
  assign rsp_fire  = rsp_valid && rsp_ready;
  assign new_word  = req_fire && emit;

  // Decoder state advances on every accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (req_fire) begin
      state <= state_next;
    end
  end

  // Output register and skid stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (rsp_fire) begin
          rsp_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (rsp_valid && !rsp_ready) begin
        if (new_word) begin
          skid_valid <= 1'b1;
        end
      end else begin
        rsp_valid <= new_word;
      end
    end
  end

  // Payload moves without reset.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (rsp_fire) begin
        rsp_word <= skid_word;
      end
    end else if (rsp_valid && !rsp_ready) begin
      if (new_word) begin
        skid_word <= result;
      end
    end else if (new_word) begin
      rsp_word <= result;
    end
  end

endmodule

### rtl/utf8_dec_checker.sv
`include "utf8_stream_decoder_core_defines.svh"

module utf8_dec_checker
  import utf8_dec_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_ready,
  input in_word_t  req_word,
  input logic      rsp_valid,
  input logic      rsp_ready,
  input out_word_t rsp_word
);

  // A stalled output word stays put.
  `UTF8_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word), "rsp word changed while stalled")

  // A replaced word always carries the replacement code point.
  `UTF8_ASSERT_NOW(a_repl_cp, clk, rst, rsp_valid && rsp_word.replaced, rsp_word.code_point == ReplacementCp, "replaced word without replacement code point")

  // Input backpressure only happens when the output is full.
  `UTF8_ASSERT_NOW(a_ready_out, clk, rst, !req_ready, rsp_valid, "input stalled with empty output")

  // The last byte of a buffer always produces a word.
  `UTF8_ASSERT_NEXT(a_end_emits, clk, rst, req_valid && req_ready && req_word.buffer_end, rsp_valid, "buffer end produced no word")

endmodule

bind utf8_stream_decoder_core utf8_dec_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req_word  (req_word),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp_word  (rsp_word)
);
